// ===== hw/rtl/share_word_packer_rs1024_unit_assert.svh =====
// Assertion macros for the share word packer RTL, included by swp_core.
`ifndef SHARE_WORD_PACKER_RS1024_UNIT_ASSERT_SVH
`define SHARE_WORD_PACKER_RS1024_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SWP_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define SWP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SWP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SWP_ASSERT_ALWAYS(lbl, expr, msg)
`define SWP_ASSERT_IMPL(lbl, ante, cons, msg)
`define SWP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/swp_pkg.sv =====
// Package: types, constants and RS1024 checksum functions of the share word packer.
`timescale 1ns / 1ps
package swp_pkg;

    localparam int MAX_VALUE_BYTES = 32;
    localparam int IN_DATA_W       = 8;
    localparam int OUT_DATA_W      = 16;
    localparam int WORD_W          = 10;
    localparam int CFG_DATA_W      = 15;
    localparam int CFG_INDEX_W     = 3;
    localparam int LEN_W           = 6;
    localparam int CHK_W           = 30;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SHARE_ID     = 3'd0,
        REG_ITER_EXP     = 3'd1,
        REG_GROUP_INDEX  = 3'd2,
        REG_GROUP_THRESH = 3'd3,
        REG_GROUP_COUNT  = 3'd4,
        REG_MEMBER_INDEX = 3'd5,
        REG_MEMBER_THRESH= 3'd6,
        REG_VALUE_LENGTH = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_HDR0 = 3'd0,
        S_HDR1 = 3'd1,
        S_HDR2 = 3'd2,
        S_HDR3 = 3'd3,
        S_DATA = 3'd4,
        S_CHK0 = 3'd5,
        S_CHK1 = 3'd6,
        S_CHK2 = 3'd7
    } step_t;

    // Header words and share geometry derived from the configuration.
    typedef struct packed {
        logic [WORD_W-1:0] hdr0;
        logic [WORD_W-1:0] hdr1;
        logic [WORD_W-1:0] hdr2;
        logic [WORD_W-1:0] hdr3;
        logic [LEN_W-1:0]  eff_len;
        logic [3:0]        pad;
    } swp_cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } swp_word_t;

    localparam logic [CHK_W-1:0] RS_GEN [10] = '{
        30'h00E0E040, 30'h01C1C080, 30'h03838100, 30'h07070200, 30'h0E0E0009,
        30'h1C0C2412, 30'h38086C24, 30'h3090FC48, 30'h21B1F890, 30'h03F3F120
    };

    function automatic logic [CHK_W-1:0] rs_step(input logic [CHK_W-1:0] c,
                                                 input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] top;
        logic [CHK_W-1:0]  r;
        top = c[CHK_W-1:20];
        r   = {c[19:0], v};
        for (int i = 0; i < 10; i++) begin
            if (top[i])
            begin
                r = r ^ RS_GEN[i];
            end
        end
        return r;
    endfunction

    // Polymod over the customization string, starting from 1.
    function automatic logic [CHK_W-1:0] rs_seed();
        logic [47:0]      pfx;
        logic [CHK_W-1:0] c;
        pfx = "shamir";
        c   = 30'd1;
        for (int i = 0; i < 6; i++) begin
            c = rs_step(c, {2'b00, pfx[47 - 8*i -: 8]});
        end
        return c;
    endfunction

    localparam logic [CHK_W-1:0] RS_SEED = rs_seed();

endpackage

// ===== hw/rtl/swp_cfg_regs.sv =====
// Configuration registers and the header words and share geometry built from them.
`timescale 1ns / 1ps
module swp_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [swp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [swp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output swp_pkg::swp_cfg_t              cfg
);
    import swp_pkg::*;

    logic [14:0] share_id_reg;
    logic [4:0]  iter_exp_reg;
    logic [3:0]  group_index_reg;
    logic [4:0]  group_thresh_reg;
    logic [4:0]  group_count_reg;
    logic [3:0]  member_index_reg;
    logic [4:0]  member_thresh_reg;
    logic [5:0]  value_length_reg;

    logic [3:0]       gt_code;
    logic [3:0]       gc_code;
    logic [3:0]       mt_code;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] len_mod5;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            share_id_reg      <= '0;
            iter_exp_reg      <= '0;
            group_index_reg   <= '0;
            group_thresh_reg  <= 5'd1;
            group_count_reg   <= 5'd1;
            member_index_reg  <= '0;
            member_thresh_reg <= 5'd1;
            value_length_reg  <= 6'd16;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SHARE_ID:      share_id_reg      <= cfg_wdata[14:0];
                REG_ITER_EXP:      iter_exp_reg      <= cfg_wdata[4:0];
                REG_GROUP_INDEX:   group_index_reg   <= cfg_wdata[3:0];
                REG_GROUP_THRESH:  group_thresh_reg  <= cfg_wdata[4:0];
                REG_GROUP_COUNT:   group_count_reg   <= cfg_wdata[4:0];
                REG_MEMBER_INDEX:  member_index_reg  <= cfg_wdata[3:0];
                REG_MEMBER_THRESH: member_thresh_reg <= cfg_wdata[4:0];
                REG_VALUE_LENGTH:  value_length_reg  <= cfg_wdata[5:0];
            endcase
        end
    end

    always_comb begin
        // thresholds and count are coded as value minus one, wrapping at zero
        gt_code = group_thresh_reg[3:0] - 4'd1;
        gc_code = group_count_reg[3:0] - 4'd1;
        mt_code = member_thresh_reg[3:0] - 4'd1;

        if (value_length_reg == '0)
        begin
            len = 6'd1;
        end
        else if (value_length_reg > LEN_W'(MAX_VALUE_BYTES))
        begin
            len = LEN_W'(MAX_VALUE_BYTES);
        end
        else
        begin
            len = value_length_reg;
        end

        // len mod 5 by compare and subtract; zero padding is 2 * (len mod 5)
        len_mod5 = len;
        if (len_mod5 >= 6'd40)
        begin
            len_mod5 = len_mod5 - 6'd40;
        end
        if (len_mod5 >= 6'd20)
        begin
            len_mod5 = len_mod5 - 6'd20;
        end
        if (len_mod5 >= 6'd10)
        begin
            len_mod5 = len_mod5 - 6'd10;
        end
        if (len_mod5 >= 6'd5)
        begin
            len_mod5 = len_mod5 - 6'd5;
        end

        cfg.hdr0    = share_id_reg[14:5];
        cfg.hdr1    = {share_id_reg[4:0], iter_exp_reg};
        cfg.hdr2    = {group_index_reg, gt_code, gc_code[3:2]};
        cfg.hdr3    = {gc_code[1:0], member_index_reg, mt_code};
        cfg.eff_len = len;
        cfg.pad     = {len_mod5[2:0], 1'b0};
    end

endmodule

// ===== hw/rtl/swp_core.sv =====
// Input register, word sequencer, bit regrouping and RS1024 checksum.
`timescale 1ns / 1ps
`include "share_word_packer_rs1024_unit_assert.svh"
module swp_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swp_pkg::swp_cfg_t             cfg,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [swp_pkg::IN_DATA_W-1:0] s_axis_tdata,   // [7:0] value_byte
    input  logic                          out_space,
    output logic                          out_load,
    output swp_pkg::swp_word_t            out_item
);
    import swp_pkg::*;

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    step_t            step_reg, step_next;
    logic [8:0]       acc_reg, acc_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [LEN_W-1:0] bt_reg, bt_next;
    logic [CHK_W-1:0] chk_reg, chk_next;
    logic [CHK_W-1:0] fin_reg, fin_next;

    logic [4:0]       cnt_sum;
    logic [4:0]       sh_full;
    logic [2:0]       sh;
    logic [16:0]      acc_new;
    logic [16:0]      acc_shift;
    logic [WORD_W-1:0] data_word;
    logic             need_emit;
    logic [3:0]       cnt_left;
    logic [8:0]       acc_left;
    logic [LEN_W-1:0] bt_inc;
    logic             is_last;
    logic [CHK_W-1:0] fin;
    logic             done;
    logic             accept;

    always_comb begin
        cnt_sum   = {1'b0, cnt_reg} + 5'd8;
        need_emit = (cnt_sum >= 5'd10);
        sh_full   = cnt_sum - 5'd10;
        sh        = sh_full[2:0];
        acc_new   = {acc_reg, in_byte_reg};
        acc_shift = acc_new >> sh;
        data_word = acc_shift[WORD_W-1:0];
        cnt_left  = need_emit ? {1'b0, sh} : cnt_sum[3:0];
        for (int i = 0; i < 9; i++) begin
            acc_left[i] = acc_new[i] & (4'(i) < cnt_left);
        end
        bt_inc  = bt_reg + 6'd1;
        is_last = (bt_inc >= cfg.eff_len);
        fin     = rs_step(rs_step(rs_step(chk_reg, '0), '0), '0) ^ 30'd1;
    end

    // one output word per cycle at most; a data byte that completes no word does not wait for output space
    always_comb begin
        step_next     = step_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        bt_next       = bt_reg;
        chk_next      = chk_reg;
        fin_next      = fin_reg;
        out_load      = 1'b0;
        out_item.word = '0;
        out_item.last = 1'b0;
        done          = 1'b0;

        if (in_valid_reg)
        begin
            unique case (step_reg)
                S_HDR0:
                begin
                    if (out_space)
                    begin
                        out_load      = 1'b1;
                        out_item.word = cfg.hdr0;
                        chk_next      = rs_step(RS_SEED, cfg.hdr0);
                        step_next     = S_HDR1;
                    end
                end
                S_HDR1:
                begin
                    if (out_space)
                    begin
                        out_load      = 1'b1;
                        out_item.word = cfg.hdr1;
                        chk_next      = rs_step(chk_reg, cfg.hdr1);
                        step_next     = S_HDR2;
                    end
                end
                S_HDR2:
                begin
                    if (out_space)
                    begin
                        out_load      = 1'b1;
                        out_item.word = cfg.hdr2;
                        chk_next      = rs_step(chk_reg, cfg.hdr2);
                        step_next     = S_HDR3;
                    end
                end
                S_HDR3:
                begin
                    if (out_space)
                    begin
                        out_load      = 1'b1;
                        out_item.word = cfg.hdr3;
                        chk_next      = rs_step(chk_reg, cfg.hdr3);
                        acc_next      = '0;
                        cnt_next      = cfg.pad;
                        step_next     = S_DATA;
                    end
                end
                S_DATA:
                begin
                    if (!need_emit || out_space)
                    begin
                        if (need_emit)
                        begin
                            out_load      = 1'b1;
                            out_item.word = data_word;
                            chk_next      = rs_step(chk_reg, data_word);
                        end
                        acc_next = acc_left;
                        cnt_next = cnt_left;
                        bt_next  = bt_inc;
                        if (is_last)
                        begin
                            step_next = S_CHK0;
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    end
                end
                S_CHK0:
                begin
                    if (out_space)
                    begin
                        out_load      = 1'b1;
                        out_item.word = fin[29:20];
                        fin_next      = fin;
                        step_next     = S_CHK1;
                    end
                end
                S_CHK1:
                begin
                    if (out_space)
                    begin
                        out_load      = 1'b1;
                        out_item.word = fin_reg[19:10];
                        step_next     = S_CHK2;
                    end
                end
                S_CHK2:
                begin
                    if (out_space)
                    begin
                        out_load      = 1'b1;
                        out_item.word = fin_reg[9:0];
                        out_item.last = 1'b1;
                        bt_next       = '0;
                        acc_next      = '0;
                        cnt_next      = '0;
                        chk_next      = RS_SEED;
                        step_next     = S_HDR0;
                        done          = 1'b1;
                    end
                end
            endcase
        end
    end

    assign s_axis_tready = !in_valid_reg || done;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = accept ? 1'b1 : (done ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            step_reg     <= S_HDR0;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            bt_reg       <= '0;
            chk_reg      <= RS_SEED;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            step_reg     <= step_next;
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            bt_reg       <= bt_next;
            chk_reg      <= chk_next;
        end
    end

    always_ff @(posedge clk) begin
        if (accept)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        fin_reg <= fin_next;
    end

    `SWP_ASSERT_ALWAYS(a_cnt_range, cnt_reg <= 4'd9, "bit count above nine")
    `SWP_ASSERT_ALWAYS(a_acc_clean, (acc_reg >> cnt_reg) == 9'd0, "stale accumulator bits")
    `SWP_ASSERT_IMPL(a_hdr_first, in_valid_reg && (step_reg == S_HDR0 || step_reg == S_HDR1 || step_reg == S_HDR2 || step_reg == S_HDR3), bt_reg == '0, "header outside share start")
    `SWP_ASSERT_NEXT(a_share_end, out_load && out_item.last, bt_reg == '0 && chk_reg == RS_SEED, "share state not cleared")

endmodule

// ===== hw/rtl/swp_out_reg.sv =====
// Output register holding one result word for the master side.
`timescale 1ns / 1ps
module swp_out_reg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  swp_pkg::swp_word_t             item,
    output logic                           space,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [swp_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [9:0] word_index, upper bits zero
    output logic                           m_axis_tlast   // last_word
);
    import swp_pkg::*;

    logic              valid_reg, valid_next;
    logic [WORD_W-1:0] word_reg;
    logic              last_reg;

    assign space      = !valid_reg || m_axis_tready;
    assign valid_next = load ? 1'b1 : (m_axis_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load)
        begin
            word_reg <= item.word;
            last_reg <= item.last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - WORD_W)'(0), word_reg};
    assign m_axis_tlast  = last_reg;

endmodule

// ===== hw/rtl/share_word_packer_rs1024_unit.sv =====
// Top level of the share word packer: bytes in, header/data/RS1024 checksum words out.
//
//  channel   direction  payload
//  s_axis    in         tdata[7:0] value_byte
//  m_axis    out        tdata[9:0] word_index, tlast last_word
//  cfg       in         cfg_wr_en, cfg_index[2:0], cfg_wdata[14:0]
//
// A byte that completes no word does not wait for output space; one that completes a word does.
// The first byte of a share first sends the four header words, then enters the data step.
// After the last byte of a share, the three checksum words follow.
// Pacing is set by the single output register, which takes one word per cycle when it has space.
// Reset loads the register defaults and the seeded checksum; there is no clearing pass.
// A low m_axis_tready holds the output word and any input byte that must emit a word.
`timescale 1ns / 1ps
module share_word_packer_rs1024_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [swp_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [7:0] value_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [swp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [9:0] word_index, [15:10] zero
    output logic                            m_axis_tlast,   // last_word
    input  logic                            cfg_wr_en,
    input  logic [swp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [swp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import swp_pkg::*;

    swp_cfg_t  cfg;
    swp_word_t out_item;
    logic      out_load;
    logic      out_space;

    swp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    swp_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .out_space     (out_space),
        .out_load      (out_load),
        .out_item      (out_item)
    );

    swp_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .item          (out_item),
        .space         (out_space),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
